### rtl/ntwa_pkg.sv
// Shared types and constants for the neighbor table with aging.
`default_nettype none

package ntwa_pkg;

  localparam int ADDR_W     = 48;
  localparam int TIME_W     = 63;
  localparam int LIMIT_W    = 32;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 4;
  localparam int TOTAL_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;

  localparam logic [LIMIT_W-1:0] EXPIRY_RESET = 32'd30000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ADDRESS  = 1'b0,
    CFG_EXPIRY_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_EXPIRE = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED       = 4'd0,
    ST_REFRESHED   = 4'd1,
    ST_SELF        = 4'd2,
    ST_FULL        = 4'd3,
    ST_REMOVED     = 4'd4,
    ST_ABSENT      = 4'd5,
    ST_PRESENT     = 4'd6,
    ST_EXPIRED     = 4'd7,
    ST_EXPIRE_DONE = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_SHIFT,
    S_EXP_COUNT,
    S_EXP_SWEEP,
    S_FINISH
  } ntwa_state_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_REFRESH,
    WR_APPEND,
    WR_SHIFT,
    WR_KEEP
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_LOAD_WR
  } cnt_op_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_EXPIRED,
    EMIT_FINAL
  } emit_op_t;

  typedef struct packed {
    logic     take_req;
    logic     walk;
    logic     restart;
    logic     replay;
    logic     rewind;
    logic     count_old;
    wr_op_t   wr_op;
    cnt_op_t  cnt_op;
    logic     set_code;
    status_t  code;
    emit_op_t emit_op;
  } ntwa_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  own_hit;
    logic  dv;
    logic  match;
    logic  old;
    logic  done;
    logic  full;
    logic  out_free;
  } ntwa_stat_t;

endpackage

`default_nettype wire

### rtl/ntwa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ntwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/ntwa_ctrl.sv
// Controller state machine sequencing table walks for each request.
`default_nettype none

module ntwa_ctrl import ntwa_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire ntwa_stat_t stat,
  output ntwa_cmd_t       cmd
);

  ntwa_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.kind == KIND_ADD && stat.own_hit) state_next = S_FINISH;
        else if (stat.kind == KIND_EXPIRE) state_next = S_EXP_COUNT;
        else state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (stat.dv && stat.match) begin
          state_next = (stat.kind == KIND_REMOVE) ? S_SHIFT : S_FINISH;
        end else if (!stat.dv && stat.done) begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (!stat.dv && stat.done) state_next = S_FINISH;
      end
      S_EXP_COUNT: begin
        if (!stat.dv && stat.done) state_next = S_EXP_SWEEP;
      end
      S_EXP_SWEEP: begin
        if (!stat.dv && stat.done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = (state != S_IDLE);
    cmd           = '0;
    cmd.wr_op     = WR_NONE;
    cmd.cnt_op    = CNT_HOLD;
    cmd.code      = ST_ADDED;
    cmd.emit_op   = EMIT_NONE;
    unique case (state)
      S_IDLE: begin
        cmd.take_req = in_valid;
      end
      S_DISPATCH: begin
        if (stat.kind == KIND_ADD && stat.own_hit) begin
          cmd.set_code = 1'b1;
          cmd.code     = ST_SELF;
        end
      end
      S_SEARCH: begin
        if (stat.dv && stat.match) begin
          case (stat.kind)
            KIND_ADD: begin
              cmd.wr_op    = WR_REFRESH;
              cmd.set_code = 1'b1;
              cmd.code     = ST_REFRESHED;
            end
            KIND_REMOVE: begin
              cmd.restart = 1'b1;
            end
            default: begin
              cmd.set_code = 1'b1;
              cmd.code     = ST_PRESENT;
            end
          endcase
        end else begin
          cmd.walk = 1'b1;
          if (!stat.dv && stat.done) begin
            cmd.set_code = 1'b1;
            if (stat.kind == KIND_ADD) begin
              if (stat.full) begin
                cmd.code = ST_FULL;
              end else begin
                cmd.code   = ST_ADDED;
                cmd.wr_op  = WR_APPEND;
                cmd.cnt_op = CNT_INC;
              end
            end else begin
              cmd.code = ST_ABSENT;
            end
          end
        end
      end
      S_SHIFT: begin
        cmd.walk = 1'b1;
        if (stat.dv) cmd.wr_op = WR_SHIFT;
        if (!stat.dv && stat.done) begin
          cmd.cnt_op   = CNT_DEC;
          cmd.set_code = 1'b1;
          cmd.code     = ST_REMOVED;
        end
      end
      S_EXP_COUNT: begin
        if (!stat.dv && stat.done) begin
          cmd.rewind = 1'b1;
        end else begin
          cmd.walk      = 1'b1;
          cmd.count_old = stat.dv && stat.old;
        end
      end
      S_EXP_SWEEP: begin
        if (stat.dv && stat.old && !stat.out_free) begin
          // result slot busy: read this entry again
          cmd.replay = 1'b1;
        end else begin
          cmd.walk = 1'b1;
          if (stat.dv && stat.old) cmd.emit_op = EMIT_EXPIRED;
          if (stat.dv && !stat.old) cmd.wr_op = WR_KEEP;
          if (!stat.dv && stat.done) begin
            cmd.cnt_op   = CNT_LOAD_WR;
            cmd.set_code = 1'b1;
            cmd.code     = ST_EXPIRE_DONE;
          end
        end
      end
      S_FINISH: begin
        if (stat.out_free) cmd.emit_op = EMIT_FINAL;
      end
      default: begin
        cmd.take_req = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/ntwa_dpath.sv
// Datapath: config registers, table RAM, walk pointers and result register.
`default_nettype none

module ntwa_dpath import ntwa_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [KIND_W-1:0]     kind,
  input  wire logic [ADDR_W-1:0]     address,
  input  wire logic [TIME_W-1:0]     time_us,
  input  wire ntwa_cmd_t             cmd,
  output ntwa_stat_t                 stat,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output logic [STATUS_W-1:0]        status,
  output logic [ADDR_W-1:0]          expired_address,
  output logic [TOTAL_W-1:0]         entry_total,
  output logic                       last
);

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = ADDR_W + TIME_W;

  logic [ADDR_W-1:0]  own_address;
  logic [LIMIT_W-1:0] expiry_limit;
  kind_t              req_kind;
  logic [ADDR_W-1:0]  req_addr;
  logic [TIME_W-1:0]  req_time;
  status_t            code;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_idx;
  logic [IDX_W-1:0] d_idx;
  logic             dv;
  logic [CNT_W-1:0] wr_ptr;
  logic [CNT_W-1:0] gone_cnt;
  logic [CNT_W-1:0] final_total;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ADDR_W-1:0]  rd_addr;
  logic [TIME_W-1:0]  rd_time;
  logic [TIME_W:0]    age;
  logic               issue;
  logic               out_free;

  ntwa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_addr  = ram_rdata[ENTRY_W-1:TIME_W];
  assign rd_time  = ram_rdata[TIME_W-1:0];
  // borrow set means the entry was seen later than now
  assign age      = {1'b0, req_time} - {1'b0, rd_time};
  assign issue    = cmd.walk && (rd_idx < count);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    stat.kind     = req_kind;
    stat.own_hit  = (req_addr == own_address);
    stat.dv       = dv;
    stat.match    = (rd_addr == req_addr);
    stat.old      = !age[TIME_W] && (age[TIME_W-1:0] > TIME_W'(expiry_limit));
    stat.done     = (rd_idx >= count);
    stat.full     = (count >= CNT_W'(TABLE_DEPTH));
    stat.out_free = out_free;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = d_idx;
    ram_wdata = {req_addr, req_time};
    case (cmd.wr_op)
      WR_REFRESH: begin
        ram_we = 1'b1;
      end
      WR_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = count[IDX_W-1:0];
      end
      WR_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = d_idx - IDX_W'(1);
        ram_wdata = ram_rdata;
      end
      WR_KEEP: begin
        ram_we    = 1'b1;
        ram_waddr = wr_ptr[IDX_W-1:0];
        ram_wdata = ram_rdata;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address  <= '0;
      expiry_limit <= EXPIRY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_OWN_ADDRESS:  own_address  <= cfg_data[ADDR_W-1:0];
        CFG_EXPIRY_LIMIT: expiry_limit <= cfg_data[LIMIT_W-1:0];
        default:          own_address  <= own_address;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      req_kind <= kind_t'(kind);
      req_addr <= address;
      req_time <= time_us;
    end
    if (cmd.set_code) code <= cmd.code;
    if (cmd.rewind) final_total <= count - gone_cnt;
    d_idx <= rd_idx[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      rd_idx   <= '0;
      dv       <= 1'b0;
      wr_ptr   <= '0;
      gone_cnt <= '0;
    end else begin
      dv <= issue;
      if (cmd.take_req) begin
        rd_idx   <= '0;
        wr_ptr   <= '0;
        gone_cnt <= '0;
        dv       <= 1'b0;
      end else if (cmd.restart) begin
        rd_idx <= CNT_W'(d_idx) + CNT_W'(1);
        dv     <= 1'b0;
      end else if (cmd.replay) begin
        rd_idx <= CNT_W'(d_idx);
        dv     <= 1'b0;
      end else if (cmd.rewind) begin
        rd_idx <= '0;
        wr_ptr <= '0;
        dv     <= 1'b0;
      end else if (issue) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      if (cmd.count_old) gone_cnt <= gone_cnt + CNT_W'(1);
      if (cmd.wr_op == WR_KEEP) wr_ptr <= wr_ptr + CNT_W'(1);
      case (cmd.cnt_op)
        CNT_INC:     count <= count + CNT_W'(1);
        CNT_DEC:     count <= count - CNT_W'(1);
        CNT_LOAD_WR: count <= wr_ptr;
        default:     count <= count;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_op != EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit_op)
      EMIT_EXPIRED: begin
        status          <= ST_EXPIRED;
        expired_address <= rd_addr;
        entry_total     <= TOTAL_W'(final_total);
        last            <= 1'b0;
      end
      EMIT_FINAL: begin
        status          <= code;
        expired_address <= '0;
        entry_total     <= TOTAL_W'(count);
        last            <= 1'b1;
      end
      default: status <= status;
    endcase
  end

endmodule

`default_nettype wire

### rtl/neighbor_table_with_aging_top.sv
// Neighbor table with aging: a packed MAC address table with last-seen times.
//
// Request channel (in_valid/in_stall) carries kind, address and time_us; the
// result channel (out_valid/out_stall) carries status, expired_address,
// entry_total and last. A request is taken when in_valid is high and
// in_stall low; one request is worked on at a time. Add, remove and query
// give one result; expire gives one result per expired entry, then a done
// result with last set. Configuration writes (cfg_write, cfg_index,
// cfg_data) are registered; the user must make them only while no request
// is in flight, and the block itself does not enforce this. Add and query
// walk the table once; remove adds a shift pass from the hit to the end;
// expire makes a counting pass and a compaction pass. All walks read the
// single table RAM one entry per cycle unless an expire sweep is held by a
// busy result slot. A stalled result holds in the output register; the next
// request is still accepted, and an expire sweep rereads the pending entry
// until the result slot frees. Reset empties the table and restores
// own_address 0 and a 30000000 us expiry limit; no clearing pass is needed.
`default_nettype none

module neighbor_table_with_aging_top import ntwa_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [KIND_W-1:0]     kind,
  input  wire logic [ADDR_W-1:0]     address,
  input  wire logic [TIME_W-1:0]     time_us,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [STATUS_W-1:0]        status,
  output logic [ADDR_W-1:0]          expired_address,
  output logic [TOTAL_W-1:0]         entry_total,
  output logic                       last
);

  ntwa_cmd_t  cmd;
  ntwa_stat_t stat;

  ntwa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ntwa_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .address         (address),
    .time_us         (time_us),
    .cmd             (cmd),
    .stat            (stat),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .status          (status),
    .expired_address (expired_address),
    .entry_total     (entry_total),
    .last            (last)
  );

endmodule

`default_nettype wire
